// ===== hdl/two_point_sine_phasor_estimator_defines.svh =====
// Assertion macros used by the phasor estimator controller.
`ifndef TWO_POINT_SINE_PHASOR_ESTIMATOR_DEFINES_SVH
`define TWO_POINT_SINE_PHASOR_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPSPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPSPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tpspe_pkg.sv =====
// Shared types, constants and tables of the two-point sine phasor estimator.
`timescale 1ns / 1ps
package tpspe_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam logic [15:0] PAIR_MAX = 16'hFFFF;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

    // Arctangent of 2^-i in 2^-32 turns.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_COUNT, OP_PHASE1, OP_PHASE2, OP_ROT_P1, OP_ROT_P2,
        OP_MUL_A, OP_MUL_S, OP_MUL_B, OP_MUL_C, OP_NORM_INIT, OP_NORM_STEP,
        OP_VEC_START, OP_ROT_Q1, OP_ROT_Q2, OP_PICK_ROTF, OP_MUL_RE, OP_DIV_RE,
        OP_ADD_RE, OP_DIV_IM, OP_ADD_IM, OP_FINISH, OP_DIV_MRE, OP_DIV_MIM,
        OP_OUT_FAIL, OP_OUT_MEAN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic form_pair;
        logic pair_zero;
        logic c_zero;
        logic norm_done;
        logic q_zero;
        logic cordic_busy;
        logic div_busy;
        logic last;
        logic count_zero;
    } t_status;

endpackage

// ===== hdl/tpspe_if.sv =====
// Handshake channel interfaces of the phasor estimator.
`timescale 1ns / 1ps
interface tpspe_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic               last_sample;
    modport source (output valid, sample_time, sample_value, last_sample, input ready);
    modport sink (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

interface tpspe_phasor_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] phasor_real;
    logic signed [31:0] phasor_imag;
    logic [15:0]        pairs_used;
    logic               fit_failed;
    modport source (output valid, phasor_real, phasor_imag, pairs_used, fit_failed,
                    input ready);
    modport sink (input valid, phasor_real, phasor_imag, pairs_used, fit_failed,
                  output ready);
endinterface

interface tpspe_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] freq_step;
    modport source (output valid, freq_step, input ready);
    modport sink (input valid, freq_step, output ready);
endinterface

// ===== hdl/tpspe_div.sv =====
// Iterative signed divider, one quotient bit a cycle, saturated 32-bit quotient.
`timescale 1ns / 1ps
module tpspe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic signed [33:0] i_divisor,
    output logic               o_busy,
    output logic signed [31:0] o_quot
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [34:0] r_rem;
    logic [63:0] r_num;
    logic [33:0] r_den;
    logic        r_neg;
    logic signed [31:0] r_quot;

    logic [34:0] shifted;
    logic        ge;
    logic [63:0] n_num;
    logic [34:0] n_rem;
    logic signed [31:0] n_quot;

    // One restoring step, and saturation of the finished magnitude.
    always_comb begin
        shifted = {r_rem[33:0], r_num[63]};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? shifted - {1'b0, r_den} : shifted;
        n_num   = {r_num[62:0], ge};
        if (!r_neg) begin
            n_quot = (n_num[63:31] != 33'd0) ? 32'sh7FFFFFFF : signed'(n_num[31:0]);
        end else if ((n_num[63:32] != 32'd0) || (n_num[31] && (n_num[30:0] != 31'd0))) begin
            n_quot = 32'sh80000000;
        end else begin
            n_quot = signed'(32'd0 - n_num[31:0]);
        end
    end

    // Control: busy flag and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operands, partial remainder and result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend[63] ? 64'd0 - 64'(i_dividend) : 64'(i_dividend);
            r_den <= i_divisor[33] ? 34'd0 - 34'(i_divisor) : 34'(i_divisor);
            r_neg <= i_dividend[63] ^ i_divisor[33];
            r_rem <= 35'd0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            if (r_cnt == 6'd63) begin
                r_quot <= n_quot;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

// ===== hdl/tpspe_dp.sv =====
// Datapath: sample registers, shared multiplier, CORDIC unit, normalizer, sums.
`timescale 1ns / 1ps
module tpspe_dp #(
    parameter int CORDIC_STEPS = tpspe_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpspe_pkg::t_cmd    i_cmd,
    output tpspe_pkg::t_status o_st,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  logic [31:0]        i_sample_time,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_last_sample,
    output logic signed [31:0] o_phasor_real,
    output logic signed [31:0] o_phasor_imag,
    output logic [15:0]        o_pairs_used,
    output logic               o_fit_failed
);
    import tpspe_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    typedef enum logic [2:0] {RD_P1, RD_P2, RD_Q1, RD_Q2, RD_F, RD_VEC} t_rdest;

    // Run state and configuration.
    logic [31:0]        r_freq;
    logic [31:0]        r_prev_t, r_cur_t;
    logic signed [31:0] r_prev_v, r_cur_v;
    logic               r_have_prev, r_last;
    logic signed [47:0] r_sum_re, r_sum_im;
    logic [15:0]        r_count;

    // Pair fit working registers.
    logic [31:0]        r_p1, r_p2, r_fa;
    logic signed [33:0] r_c1, r_s1, r_c2, r_s2, r_q1, r_q2, r_cf, r_sf, r_q;
    logic signed [63:0] r_acc, r_s, r_c;
    logic [63:0]        r_ux, r_uy;
    logic               r_yneg;
    logic signed [31:0] r_v, r_mre;

    // CORDIC unit.
    logic               r_cbusy, r_cvec;
    logic [IW-1:0]      r_cidx;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_cquad;
    t_rdest             r_cdest;

    // Result word.
    logic signed [31:0] r_o_re, r_o_im;
    logic [15:0]        r_o_cnt;
    logic               r_o_fail;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic               cstart, cdone;
    logic [31:0]        rot_ang, rot_d;
    logic [1:0]         rot_quad;
    logic signed [33:0] cdx, cdy, catan, n_cx, n_cy, n_cz, rcos, rsin;
    logic [63:0]        mag;
    logic               norm_done;
    logic signed [33:0] qa1, qa2;
    logic               div_start, div_busy;
    logic signed [63:0] div_num;
    logic signed [33:0] div_den;
    logic signed [31:0] div_quot;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        unique case (i_cmd.op)
            OP_PHASE1: begin mul_a = {2'b00, r_freq}; mul_b = {2'b00, r_prev_t}; end
            OP_PHASE2: begin mul_a = {2'b00, r_freq}; mul_b = {2'b00, r_cur_t}; end
            OP_MUL_A:  begin mul_a = 34'(r_cur_v);  mul_b = r_s1; end
            OP_MUL_S:  begin mul_a = 34'(r_prev_v); mul_b = r_s2; end
            OP_MUL_B:  begin mul_a = 34'(r_cur_v);  mul_b = r_c1; end
            OP_MUL_C:  begin mul_a = 34'(r_prev_v); mul_b = r_c2; end
            OP_MUL_RE: begin mul_a = 34'(r_v);      mul_b = r_cf; end
            OP_ADD_RE: begin mul_a = 34'(r_v);      mul_b = r_sf; end
            default: begin end
        endcase
        mul_p = mul_a * mul_b;
    end

    // CORDIC start decode and start angle.
    always_comb begin
        cstart  = 1'b0;
        rot_ang = r_fa;
        case (i_cmd.op)
            OP_ROT_P1: begin cstart = 1'b1; rot_ang = r_p1; end
            OP_ROT_P2: begin cstart = 1'b1; rot_ang = r_p2; end
            OP_ROT_Q1: begin cstart = 1'b1; rot_ang = r_p1 + r_fa; end
            OP_ROT_Q2: begin cstart = 1'b1; rot_ang = r_p2 + r_fa; end
            OP_PICK_ROTF, OP_VEC_START: begin cstart = 1'b1; end
            default: begin end
        endcase
        rot_quad = 2'((rot_ang + 32'h20000000) >> 30);
        rot_d    = rot_ang - {rot_quad, 30'd0};
    end

    // One CORDIC micro-rotation, then the quadrant fix of the result.
    always_comb begin
        cdx   = r_cy >>> r_cidx;
        cdy   = r_cx >>> r_cidx;
        catan = 34'(ATAN_TURNS[5'(r_cidx)]);
        if (r_cvec ? !r_cy[33] : r_cz[33]) begin
            n_cx = r_cx + cdx;
            n_cy = r_cy - cdy;
            n_cz = r_cz + catan;
        end else begin
            n_cx = r_cx - cdx;
            n_cy = r_cy + cdy;
            n_cz = r_cz - catan;
        end
        case (r_cquad)
            2'd0:    begin rcos = n_cx;  rsin = n_cy;  end
            2'd1:    begin rcos = -n_cy; rsin = n_cx;  end
            2'd2:    begin rcos = -n_cx; rsin = -n_cy; end
            default: begin rcos = n_cy;  rsin = -n_cx; end
        endcase
        cdone = r_cbusy && (r_cidx == IW'(CORDIC_STEPS - 1));
    end

    // Normalizer magnitude and sine magnitudes.
    always_comb begin
        mag       = (r_ux > r_uy) ? r_ux : r_uy;
        norm_done = (mag[63:30] == 34'd0) && mag[29];
        qa1       = r_q1[33] ? -r_q1 : r_q1;
        qa2       = r_q2[33] ? -r_q2 : r_q2;
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_num   = r_acc;
        div_den   = r_q;
        case (i_cmd.op)
            OP_DIV_RE, OP_DIV_IM: div_start = 1'b1;
            OP_DIV_MRE: begin
                div_start = 1'b1;
                div_num   = 64'(r_sum_re);
                div_den   = {18'd0, r_count};
            end
            OP_DIV_MIM: begin
                div_start = 1'b1;
                div_num   = 64'(r_sum_im);
                div_den   = {18'd0, r_count};
            end
            default: begin end
        endcase
    end

    tpspe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // Run state, configuration and CORDIC control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= 32'd0;
            r_prev_t    <= 32'd0;
            r_prev_v    <= 32'sd0;
            r_have_prev <= 1'b0;
            r_sum_re    <= 48'sd0;
            r_sum_im    <= 48'sd0;
            r_count     <= 16'd0;
            r_cbusy     <= 1'b0;
            r_cidx      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_freq <= i_cfg_data;
            end
            if (cstart) begin
                r_cbusy <= 1'b1;
                r_cidx  <= '0;
            end else if (r_cbusy) begin
                r_cidx <= IW'(r_cidx + 1'b1);
                if (cdone) begin
                    r_cbusy <= 1'b0;
                end
            end
            unique case (i_cmd.op)
                OP_COUNT: r_count <= r_count + 16'd1;
                OP_ADD_RE: r_sum_re <= r_sum_re + 48'(div_quot);
                OP_ADD_IM: begin
                    r_sum_im <= r_sum_im + 48'(div_quot);
                    r_count  <= r_count + 16'd1;
                end
                OP_FINISH: begin
                    r_prev_t    <= r_cur_t;
                    r_prev_v    <= r_cur_v;
                    r_have_prev <= 1'b1;
                end
                OP_OUT_FAIL, OP_OUT_MEAN: begin
                    r_prev_t    <= 32'd0;
                    r_prev_v    <= 32'sd0;
                    r_have_prev <= 1'b0;
                    r_sum_re    <= 48'sd0;
                    r_sum_im    <= 48'sd0;
                    r_count     <= 16'd0;
                end
                default: begin end
            endcase
        end
    end

    // Working registers of the pair fit and the result word.
    always_ff @(posedge i_clk) begin
        if (cstart) begin
            r_cvec  <= (i_cmd.op == OP_VEC_START);
            r_cquad <= rot_quad;
            if (i_cmd.op == OP_VEC_START) begin
                r_cx <= 34'(r_ux);
                r_cy <= r_yneg ? 34'sd0 - 34'(r_uy) : 34'(r_uy);
                r_cz <= 34'sd0;
            end else begin
                r_cx <= CORDIC_GAIN_INV;
                r_cy <= 34'sd0;
                r_cz <= 34'(signed'(rot_d));
            end
        end else if (r_cbusy) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
        if (cdone) begin
            case (r_cdest)
                RD_P1:   begin r_c1 <= rcos; r_s1 <= rsin; end
                RD_P2:   begin r_c2 <= rcos; r_s2 <= rsin; end
                RD_Q1:   r_q1 <= rsin;
                RD_Q2:   r_q2 <= rsin;
                RD_F:    begin r_cf <= rcos; r_sf <= rsin; end
                default: r_fa <= n_cz[31:0];
            endcase
        end
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_cur_t <= i_sample_time;
                r_cur_v <= i_sample_value;
                r_last  <= i_last_sample;
            end
            OP_PHASE1: r_p1 <= mul_p[31:0];
            OP_PHASE2: r_p2 <= mul_p[31:0];
            OP_ROT_P1: r_cdest <= RD_P1;
            OP_ROT_P2: r_cdest <= RD_P2;
            OP_ROT_Q1: r_cdest <= RD_Q1;
            OP_ROT_Q2: r_cdest <= RD_Q2;
            OP_VEC_START: r_cdest <= RD_VEC;
            OP_MUL_A, OP_MUL_B, OP_MUL_RE, OP_ADD_RE: r_acc <= mul_p[63:0];
            OP_MUL_S: r_s <= r_acc - mul_p[63:0];
            OP_MUL_C: r_c <= r_acc - mul_p[63:0];
            OP_NORM_INIT: begin
                r_ux   <= r_c[63] ? 64'd0 - 64'(r_c) : 64'(r_c);
                r_uy   <= r_s[63] ? 64'd0 - 64'(r_s) : 64'(r_s);
                r_yneg <= r_c[63] ? r_s[63] : (r_s != 64'sd0) && !r_s[63];
            end
            OP_NORM_STEP: begin
                if (!norm_done) begin
                    if (mag[63:30] != 34'd0) begin
                        r_ux <= r_ux >> 1;
                        r_uy <= r_uy >> 1;
                    end else begin
                        r_ux <= r_ux << 1;
                        r_uy <= r_uy << 1;
                    end
                end
            end
            OP_PICK_ROTF: begin
                r_cdest <= RD_F;
                if (qa2 < qa1) begin
                    r_v <= r_prev_v;
                    r_q <= r_q1;
                end else begin
                    r_v <= r_cur_v;
                    r_q <= r_q2;
                end
            end
            OP_DIV_MIM: r_mre <= div_quot;
            OP_OUT_FAIL: begin
                r_o_re   <= 32'sd0;
                r_o_im   <= 32'sd0;
                r_o_cnt  <= 16'd0;
                r_o_fail <= 1'b1;
            end
            OP_OUT_MEAN: begin
                r_o_re   <= r_mre;
                r_o_im   <= div_quot;
                r_o_cnt  <= r_count;
                r_o_fail <= 1'b0;
            end
            default: begin end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_st.form_pair   = r_have_prev && (r_count != PAIR_MAX);
        o_st.pair_zero   = (r_prev_v == 32'sd0) && (r_cur_v == 32'sd0);
        o_st.c_zero      = (r_c == 64'sd0);
        o_st.norm_done   = norm_done;
        o_st.q_zero      = (r_q1 == 34'sd0) && (r_q2 == 34'sd0);
        o_st.cordic_busy = r_cbusy;
        o_st.div_busy    = div_busy;
        o_st.last        = r_last;
        o_st.count_zero  = (r_count == 16'd0);
    end

    assign o_phasor_real = r_o_re;
    assign o_phasor_imag = r_o_im;
    assign o_pairs_used  = r_o_cnt;
    assign o_fit_failed  = r_o_fail;
endmodule

// ===== hdl/tpspe_ctrl.sv =====
// Controller: sequences the pair fit and the mean, and owns the sample and result handshakes.
`timescale 1ns / 1ps
module tpspe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tpspe_pkg::t_cmd    o_cmd,
    input  tpspe_pkg::t_status i_st
);
    import tpspe_pkg::*;
    `include "two_point_sine_phasor_estimator_defines.svh"

    typedef enum logic [22:0] {
        ST_IDLE   = 23'h000001,
        ST_DECIDE = 23'h000002,
        ST_PH2    = 23'h000004,
        ST_ROT1   = 23'h000008,
        ST_W_ROT1 = 23'h000010,
        ST_W_ROT2 = 23'h000020,
        ST_MUL_S  = 23'h000040,
        ST_MUL_B  = 23'h000080,
        ST_MUL_C  = 23'h000100,
        ST_CHK_C  = 23'h000200,
        ST_NORM   = 23'h000400,
        ST_W_VEC  = 23'h000800,
        ST_W_Q1   = 23'h001000,
        ST_W_Q2   = 23'h002000,
        ST_W_F    = 23'h004000,
        ST_DIV_RE = 23'h008000,
        ST_W_DRE  = 23'h010000,
        ST_DIV_IM = 23'h020000,
        ST_W_DIM  = 23'h040000,
        ST_FINISH = 23'h080000,
        ST_MEAN   = 23'h100000,
        ST_W_MRE  = 23'h200000,
        ST_W_MIM  = 23'h400000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and command.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_st.form_pair) begin
                    n_state = ST_FINISH;
                end else if (i_st.pair_zero) begin
                    o_cmd.op = OP_COUNT;
                    n_state  = ST_FINISH;
                end else begin
                    o_cmd.op = OP_PHASE1;
                    n_state  = ST_PH2;
                end
            end
            ST_PH2: begin o_cmd.op = OP_PHASE2; n_state = ST_ROT1; end
            ST_ROT1: begin o_cmd.op = OP_ROT_P1; n_state = ST_W_ROT1; end
            ST_W_ROT1: begin
                if (!i_st.cordic_busy) begin
                    o_cmd.op = OP_ROT_P2;
                    n_state  = ST_W_ROT2;
                end
            end
            ST_W_ROT2: begin
                if (!i_st.cordic_busy) begin
                    o_cmd.op = OP_MUL_A;
                    n_state  = ST_MUL_S;
                end
            end
            ST_MUL_S: begin o_cmd.op = OP_MUL_S; n_state = ST_MUL_B; end
            ST_MUL_B: begin o_cmd.op = OP_MUL_B; n_state = ST_MUL_C; end
            ST_MUL_C: begin o_cmd.op = OP_MUL_C; n_state = ST_CHK_C; end
            ST_CHK_C: begin
                if (i_st.c_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.op = OP_NORM_INIT;
                    n_state  = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_st.norm_done) begin
                    o_cmd.op = OP_VEC_START;
                    n_state  = ST_W_VEC;
                end else begin
                    o_cmd.op = OP_NORM_STEP;
                end
            end
            ST_W_VEC: begin
                if (!i_st.cordic_busy) begin
                    o_cmd.op = OP_ROT_Q1;
                    n_state  = ST_W_Q1;
                end
            end
            ST_W_Q1: begin
                if (!i_st.cordic_busy) begin
                    o_cmd.op = OP_ROT_Q2;
                    n_state  = ST_W_Q2;
                end
            end
            ST_W_Q2: begin
                if (!i_st.cordic_busy) begin
                    if (i_st.q_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.op = OP_PICK_ROTF;
                        n_state  = ST_W_F;
                    end
                end
            end
            ST_W_F: begin
                if (!i_st.cordic_busy) begin
                    o_cmd.op = OP_MUL_RE;
                    n_state  = ST_DIV_RE;
                end
            end
            ST_DIV_RE: begin o_cmd.op = OP_DIV_RE; n_state = ST_W_DRE; end
            ST_W_DRE: begin
                if (!i_st.div_busy) begin
                    o_cmd.op = OP_ADD_RE;
                    n_state  = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin o_cmd.op = OP_DIV_IM; n_state = ST_W_DIM; end
            ST_W_DIM: begin
                if (!i_st.div_busy) begin
                    o_cmd.op = OP_ADD_IM;
                    n_state  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_state  = i_st.last ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN: begin
                if (!i_st.count_zero) begin
                    o_cmd.op = OP_DIV_MRE;
                    n_state  = ST_W_MRE;
                end else if (out_free) begin
                    o_cmd.op = OP_OUT_FAIL;
                    n_state  = ST_IDLE;
                end
            end
            ST_W_MRE: begin
                if (!i_st.div_busy) begin
                    o_cmd.op = OP_DIV_MIM;
                    n_state  = ST_W_MIM;
                end
            end
            ST_W_MIM: begin
                if (!i_st.div_busy && out_free) begin
                    o_cmd.op = OP_OUT_MEAN;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_OUT_FAIL || o_cmd.op == OP_OUT_MEAN) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `TPSPE_ASSERT_NOW(a_div_idle_on_start, i_clk, i_rst_n, (o_cmd.op == OP_DIV_RE || o_cmd.op == OP_DIV_IM || o_cmd.op == OP_DIV_MRE || o_cmd.op == OP_DIV_MIM), !i_st.div_busy, "divider started while busy")
    `TPSPE_ASSERT_NOW(a_out_slot_free, i_clk, i_rst_n, (o_cmd.op == OP_OUT_FAIL || o_cmd.op == OP_OUT_MEAN), out_free, "result word overwritten")
    `TPSPE_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, (i_in_valid && o_in_ready), (r_state == ST_DECIDE && !o_in_ready), "accepted word not taken up")
endmodule

// ===== hdl/two_point_sine_phasor_estimator.sv =====
// A first sample or a zero pair goes straight to the finish step; a fitted pair runs through
// the phase products, the shared CORDIC unit, the multiplies, the normalizing shifts and
// the bit-serial divider. A last sample adds the two mean divisions; one sample at a time.
// Reset (synchronous, active low) clears the frequency, sums, count and held sample.
`timescale 1ns / 1ps
module two_point_sine_phasor_estimator #(
    parameter int CORDIC_STEPS = tpspe_pkg::CORDIC_STEPS_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    tpspe_cfg_if.sink      i_cfg,
    tpspe_sample_if.sink   i_sample,
    tpspe_phasor_if.source o_phasor
);
    import tpspe_pkg::*;

    t_cmd    cmd;
    t_status st;

    assign i_cfg.ready = 1'b1;

    tpspe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .i_out_ready (o_phasor.ready),
        .o_out_valid (o_phasor.valid),
        .o_cmd       (cmd),
        .i_st        (st)
    );

    tpspe_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_data     (i_cfg.freq_step),
        .i_sample_time  (i_sample.sample_time),
        .i_sample_value (i_sample.sample_value),
        .i_last_sample  (i_sample.last_sample),
        .o_phasor_real  (o_phasor.phasor_real),
        .o_phasor_imag  (o_phasor.phasor_imag),
        .o_pairs_used   (o_phasor.pairs_used),
        .o_fit_failed   (o_phasor.fit_failed)
    );
endmodule
